// ===== rtl/sensor_node_join_uplink_controller_assert.svh =====
// Assertion macros used by the join and uplink controller RTL.
`ifndef SENSOR_NODE_JOIN_UPLINK_CONTROLLER_ASSERT_SVH
`define SENSOR_NODE_JOIN_UPLINK_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define SNJUC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("snjuc assertion failed");

// Next-cycle implication, disabled while reset is held.
`define SNJUC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("snjuc assertion failed");

`endif

// ===== rtl/snjuc_pkg.sv =====
// Types, codes and helpers for the join and uplink controller.
package snjuc_pkg;

    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned CHAN_W   = 8;
    localparam int unsigned IDENT_W  = 8;
    localparam int unsigned CNT_W    = 16;

    localparam logic [CNT_W-1:0]  RELOAD_RESET  = 16'd300;
    localparam logic [ADDR_W-1:0] ADDR_BCAST    = {ADDR_W{1'b1}};

    // event codes
    localparam logic [1:0] CMD_INIT    = 2'd0;
    localparam logic [1:0] CMD_TICK    = 2'd1;
    localparam logic [1:0] CMD_TX_DONE = 2'd2;
    localparam logic [1:0] CMD_RX_PKT  = 2'd3;

    // received packet types
    localparam logic [2:0] PKT_DATA_REQ  = 3'd0;
    localparam logic [2:0] PKT_DATA_COMP = 3'd1;
    localparam logic [2:0] PKT_JOIN_RESP = 3'd2;
    localparam logic [2:0] PKT_WAKEUP    = 3'd3;

    // radio actions
    localparam logic [2:0] ACT_NONE        = 3'd0;
    localparam logic [2:0] ACT_JOIN_REQ    = 3'd1;
    localparam logic [2:0] ACT_JOIN_COMP   = 3'd2;
    localparam logic [2:0] ACT_UPLINK      = 3'd3;
    localparam logic [2:0] ACT_REINIT      = 3'd4;
    localparam logic [2:0] ACT_SET_CHANNEL = 3'd5;
    localparam logic [2:0] ACT_WAKE        = 3'd6;

    // reported node state codes
    localparam logic [2:0] ST_CODE_JOIN_START = 3'd0;
    localparam logic [2:0] ST_CODE_JOIN_COMP  = 3'd1;
    localparam logic [2:0] ST_CODE_UPLINK     = 3'd2;
    localparam logic [2:0] ST_CODE_SENDING    = 3'd3;
    localparam logic [2:0] ST_CODE_COUNTDOWN  = 3'd4;
    localparam logic [2:0] ST_CODE_IDLE       = 3'd5;

    typedef enum logic [5:0] {
        S_JOIN_START = 6'b000001,
        S_JOIN_COMP  = 6'b000010,
        S_UPLINK     = 6'b000100,
        S_SENDING    = 6'b001000,
        S_COUNTDOWN  = 6'b010000,
        S_IDLE       = 6'b100000
    } t_node_state;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [ADDR_W-1:0]  src_addr;
        logic [IDENT_W-1:0] pkt_identifier;
        logic [2:0]         pkt_kind;
        logic               rx_bcast;
        logic [CHAN_W-1:0]  channel_in;
        logic               channel_present;
    } t_in_req;

    typedef struct packed {
        logic [2:0]         action;
        logic [ADDR_W-1:0]  dest_addr;
        logic [IDENT_W-1:0] send_identifier;
        logic [CHAN_W-1:0]  channel_out;
        logic [2:0]         node_state_out;
    } t_out_req;

    // node context carried between requests
    typedef struct packed {
        t_node_state        node_state;
        logic [CNT_W-1:0]   countdown;
        logic [CHAN_W-1:0]  joined_channel;
        logic [ADDR_W-1:0]  gateway_addr;
        logic [IDENT_W-1:0] gateway_ident;
    } t_ctx;

    function automatic logic [2:0] state_code(input t_node_state st);
        logic [2:0] code;
        case (st)
            S_JOIN_START: code = ST_CODE_JOIN_START;
            S_JOIN_COMP:  code = ST_CODE_JOIN_COMP;
            S_UPLINK:     code = ST_CODE_UPLINK;
            S_SENDING:    code = ST_CODE_SENDING;
            S_COUNTDOWN:  code = ST_CODE_COUNTDOWN;
            S_IDLE:       code = ST_CODE_IDLE;
            default:      code = ST_CODE_JOIN_START;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/snjuc_core.sv =====
// Next-context and result logic for one request of the join and uplink controller.
module snjuc_core (
    input  snjuc_pkg::t_ctx                  i_ctx,
    input  snjuc_pkg::t_in_req               i_req,
    input  logic [snjuc_pkg::CNT_W-1:0]      i_reload,
    output snjuc_pkg::t_ctx                  o_ctx,
    output snjuc_pkg::t_out_req              o_res
);

    snjuc_pkg::t_ctx            n_ctx;
    logic [2:0]                 act;
    logic [snjuc_pkg::IDENT_W-1:0] ident;
    logic [snjuc_pkg::CNT_W-1:0]   cnt_dec;

    assign cnt_dec = i_ctx.countdown - {{(snjuc_pkg::CNT_W-1){1'b0}}, 1'b1};

    always_comb begin
        n_ctx = i_ctx;
        act   = snjuc_pkg::ACT_NONE;
        ident = '0;
        case (i_req.cmd)
            snjuc_pkg::CMD_INIT: begin
                n_ctx.countdown     = '0;
                n_ctx.gateway_addr  = '0;
                n_ctx.gateway_ident = '0;
                if (i_req.channel_present) begin
                    n_ctx.joined_channel = i_req.channel_in;
                    n_ctx.node_state     = snjuc_pkg::S_IDLE;
                    act                  = snjuc_pkg::ACT_SET_CHANNEL;
                end else begin
                    n_ctx.joined_channel = '0;
                    n_ctx.node_state     = snjuc_pkg::S_JOIN_START;
                end
            end
            snjuc_pkg::CMD_TICK: begin
                case (i_ctx.node_state)
                    snjuc_pkg::S_JOIN_START: begin
                        act              = snjuc_pkg::ACT_JOIN_REQ;
                        n_ctx.node_state = snjuc_pkg::S_SENDING;
                    end
                    snjuc_pkg::S_JOIN_COMP: begin
                        act              = snjuc_pkg::ACT_JOIN_COMP;
                        n_ctx.node_state = snjuc_pkg::S_SENDING;
                    end
                    snjuc_pkg::S_UPLINK: begin
                        act              = snjuc_pkg::ACT_UPLINK;
                        ident            = i_ctx.gateway_ident;
                        n_ctx.node_state = snjuc_pkg::S_SENDING;
                    end
                    snjuc_pkg::S_COUNTDOWN: begin
                        n_ctx.countdown = cnt_dec;
                        // expiry: rejoin if the joined channel is zero, else start over idle
                        if (cnt_dec == '0) begin
                            act              = snjuc_pkg::ACT_REINIT;
                            n_ctx.node_state = (i_ctx.joined_channel == '0) ?
                                snjuc_pkg::S_JOIN_START : snjuc_pkg::S_IDLE;
                        end
                    end
                    snjuc_pkg::S_IDLE: begin
                        n_ctx.node_state = snjuc_pkg::S_COUNTDOWN;
                        n_ctx.countdown  = i_reload;
                    end
                    default: begin
                        // sending: hold
                    end
                endcase
            end
            snjuc_pkg::CMD_TX_DONE: begin
                n_ctx.node_state = snjuc_pkg::S_IDLE;
            end
            default: begin
                // drop broadcast packets
                if (!i_req.rx_bcast) begin
                    case (i_req.pkt_kind)
                        snjuc_pkg::PKT_DATA_REQ: begin
                            n_ctx.countdown     = i_reload;
                            n_ctx.gateway_addr  = i_req.src_addr;
                            n_ctx.gateway_ident = i_req.pkt_identifier;
                            n_ctx.node_state    = snjuc_pkg::S_UPLINK;
                        end
                        snjuc_pkg::PKT_DATA_COMP: begin
                            n_ctx.countdown  = i_reload;
                            n_ctx.node_state = snjuc_pkg::S_IDLE;
                        end
                        snjuc_pkg::PKT_JOIN_RESP: begin
                            n_ctx.countdown      = i_reload;
                            n_ctx.gateway_addr   = i_req.src_addr;
                            n_ctx.gateway_ident  = i_req.pkt_identifier;
                            n_ctx.joined_channel = i_req.channel_in;
                            n_ctx.node_state     = snjuc_pkg::S_JOIN_COMP;
                            act                  = snjuc_pkg::ACT_SET_CHANNEL;
                        end
                        snjuc_pkg::PKT_WAKEUP: begin
                            n_ctx.countdown  = i_reload;
                            n_ctx.node_state = snjuc_pkg::S_IDLE;
                            act              = snjuc_pkg::ACT_WAKE;
                        end
                        default: begin
                            // other packet types: drop
                        end
                    endcase
                end
            end
        endcase
    end

    assign o_ctx                  = n_ctx;
    assign o_res.action           = act;
    assign o_res.dest_addr        = (act == snjuc_pkg::ACT_JOIN_REQ) ?
                                    snjuc_pkg::ADDR_BCAST : n_ctx.gateway_addr;
    assign o_res.send_identifier  = ident;
    assign o_res.channel_out      = n_ctx.joined_channel;
    assign o_res.node_state_out   = snjuc_pkg::state_code(n_ctx.node_state);

endmodule

// ===== rtl/sensor_node_join_uplink_controller.sv =====
// Path: input register, a single context-update pass, then the result register.
// Throughput: one request per cycle while the result register is not stalled.
// A stall holds the result register and context; the input register keeps accepting until full.
// Reset (synchronous, active low): join start, countdown/channel/gateway cleared,
// countdown reload back to 300, both pipeline registers emptied.
module sensor_node_join_uplink_controller (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  snjuc_pkg::t_in_req               i_in_req,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output snjuc_pkg::t_out_req              o_out_req,
    input  logic                             i_cfg_we,
    input  logic [snjuc_pkg::CNT_W-1:0]      i_cfg_wdata
);

    `include "sensor_node_join_uplink_controller_assert.svh"

    logic                            r_in_valid;
    snjuc_pkg::t_in_req              r_in;
    logic                            r_out_valid;
    snjuc_pkg::t_out_req             r_out;
    snjuc_pkg::t_ctx                 r_ctx;
    logic [snjuc_pkg::CNT_W-1:0]     r_reload;

    snjuc_pkg::t_ctx                 n_ctx;
    snjuc_pkg::t_out_req             n_out;
    logic                            adv;
    logic                            step;

    // advance the input register whenever the result register can take a new request
    assign adv        = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && adv;
    assign o_in_ready = !r_in_valid || adv;

    snjuc_core u_core (
        .i_ctx    (r_ctx),
        .i_req    (r_in),
        .i_reload (r_reload),
        .o_ctx    (n_ctx),
        .o_res    (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_reload    <= snjuc_pkg::RELOAD_RESET;
            r_ctx       <= '{node_state:     snjuc_pkg::S_JOIN_START,
                             countdown:      '0,
                             joined_channel: '0,
                             gateway_addr:   '0,
                             gateway_ident:  '0};
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
            if (step) begin
                r_ctx <= n_ctx;
            end
            if (i_cfg_we) begin
                r_reload <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_req;
        end
        if (step) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    `SNJUC_ASSERT_NOW(a_stall_means_full, i_clk, i_rst_n, !o_in_ready, r_in_valid && r_out_valid)
    `SNJUC_ASSERT_NEXT(a_step_gives_result, i_clk, i_rst_n, step, r_out_valid)
    `SNJUC_ASSERT_NOW(a_join_req_bcast, i_clk, i_rst_n,
        r_out_valid && (r_out.action == snjuc_pkg::ACT_JOIN_REQ),
        r_out.dest_addr == snjuc_pkg::ADDR_BCAST)
    `SNJUC_ASSERT_NOW(a_send_goes_sending, i_clk, i_rst_n,
        r_out_valid && (r_out.action == snjuc_pkg::ACT_JOIN_REQ ||
                        r_out.action == snjuc_pkg::ACT_JOIN_COMP ||
                        r_out.action == snjuc_pkg::ACT_UPLINK),
        r_out.node_state_out == snjuc_pkg::ST_CODE_SENDING)

endmodule

// ===== dv/tb_sensor_node_join_uplink_controller.sv =====
// Testbench for the join and uplink controller: random and directed events checked by scoreboard.
`timescale 1ns / 100ps

module tb_sensor_node_join_uplink_controller;

    localparam int unsigned WDOG_LIMIT   = 4000;
    localparam int unsigned SETTLE_LIMIT = 8;
    localparam logic [2:0]  PKT_OTHER    = 3'd4;

    class node_action_scoreboard;
        logic [snjuc_pkg::CNT_W-1:0]   reload;
        logic [2:0]                    st;
        logic [snjuc_pkg::CNT_W-1:0]   idle_ticks;
        logic [snjuc_pkg::CHAN_W-1:0]  chan;
        logic [snjuc_pkg::ADDR_W-1:0]  gw_addr;
        logic [snjuc_pkg::IDENT_W-1:0] gw_ident;
        snjuc_pkg::t_out_req           expected_actions[$];
        int unsigned                   n_req;
        int unsigned                   n_res;
        int unsigned                   n_bad;
        int unsigned                   act_count[8];

        function new();
            reload     = snjuc_pkg::RELOAD_RESET;
            st         = snjuc_pkg::ST_CODE_JOIN_START;
            idle_ticks = '0;
            chan       = '0;
            gw_addr    = '0;
            gw_ident   = '0;
        endfunction

        function void set_reload(input logic [snjuc_pkg::CNT_W-1:0] v);
            reload = v;
        endfunction

        function int unsigned pending();
            return expected_actions.size();
        endfunction

        // Work out the radio action for one request and advance the node context.
        function snjuc_pkg::t_out_req predict_action(input snjuc_pkg::t_in_req r);
            snjuc_pkg::t_out_req o;
            logic                bcast_dest;
            o          = '0;
            o.action   = snjuc_pkg::ACT_NONE;
            bcast_dest = 1'b0;
            case (r.cmd)
                snjuc_pkg::CMD_INIT: begin
                    idle_ticks = '0;
                    gw_addr    = '0;
                    gw_ident   = '0;
                    if (r.channel_present) begin
                        chan     = r.channel_in;
                        st       = snjuc_pkg::ST_CODE_IDLE;
                        o.action = snjuc_pkg::ACT_SET_CHANNEL;
                    end else begin
                        chan = '0;
                        st   = snjuc_pkg::ST_CODE_JOIN_START;
                    end
                end
                snjuc_pkg::CMD_TICK: begin
                    case (st)
                        snjuc_pkg::ST_CODE_JOIN_START: begin
                            o.action   = snjuc_pkg::ACT_JOIN_REQ;
                            bcast_dest = 1'b1;
                            st         = snjuc_pkg::ST_CODE_SENDING;
                        end
                        snjuc_pkg::ST_CODE_JOIN_COMP: begin
                            o.action = snjuc_pkg::ACT_JOIN_COMP;
                            st       = snjuc_pkg::ST_CODE_SENDING;
                        end
                        snjuc_pkg::ST_CODE_UPLINK: begin
                            o.action          = snjuc_pkg::ACT_UPLINK;
                            o.send_identifier = gw_ident;
                            st                = snjuc_pkg::ST_CODE_SENDING;
                        end
                        snjuc_pkg::ST_CODE_COUNTDOWN: begin
                            idle_ticks = idle_ticks - 1'b1;
                            if (idle_ticks == '0) begin
                                o.action = snjuc_pkg::ACT_REINIT;
                                st = (chan == '0) ? snjuc_pkg::ST_CODE_JOIN_START :
                                                    snjuc_pkg::ST_CODE_IDLE;
                            end
                        end
                        snjuc_pkg::ST_CODE_IDLE: begin
                            st         = snjuc_pkg::ST_CODE_COUNTDOWN;
                            idle_ticks = reload;
                        end
                        default: ;
                    endcase
                end
                snjuc_pkg::CMD_TX_DONE: st = snjuc_pkg::ST_CODE_IDLE;
                default: begin
                    // broadcast packets never reach the node logic
                    if (!r.rx_bcast) begin
                        case (r.pkt_kind)
                            snjuc_pkg::PKT_DATA_REQ: begin
                                idle_ticks = reload;
                                gw_addr    = r.src_addr;
                                gw_ident   = r.pkt_identifier;
                                st         = snjuc_pkg::ST_CODE_UPLINK;
                            end
                            snjuc_pkg::PKT_DATA_COMP: begin
                                idle_ticks = reload;
                                st         = snjuc_pkg::ST_CODE_IDLE;
                            end
                            snjuc_pkg::PKT_JOIN_RESP: begin
                                idle_ticks = reload;
                                gw_addr    = r.src_addr;
                                gw_ident   = r.pkt_identifier;
                                chan       = r.channel_in;
                                o.action   = snjuc_pkg::ACT_SET_CHANNEL;
                                st         = snjuc_pkg::ST_CODE_JOIN_COMP;
                            end
                            snjuc_pkg::PKT_WAKEUP: begin
                                idle_ticks = reload;
                                o.action   = snjuc_pkg::ACT_WAKE;
                                st         = snjuc_pkg::ST_CODE_IDLE;
                            end
                            default: ;
                        endcase
                    end
                end
            endcase
            o.dest_addr      = bcast_dest ? snjuc_pkg::ADDR_BCAST : gw_addr;
            o.channel_out    = chan;
            o.node_state_out = st;
            return o;
        endfunction

        function void note_request(input snjuc_pkg::t_in_req r);
            expected_actions.push_back(predict_action(r));
            n_req++;
        endfunction

        function void show(input string tag, input snjuc_pkg::t_out_req v);
            $display("    %s act=%0d dest=%h id=%h ch=%h st=%0d", tag, v.action, v.dest_addr,
                     v.send_identifier, v.channel_out, v.node_state_out);
        endfunction

        function void check_response(input snjuc_pkg::t_out_req got);
            snjuc_pkg::t_out_req want;
            string               wrong;
            n_res++;
            if (expected_actions.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) begin
                    $display("%0t result with nothing outstanding", $time);
                    show("got     ", got);
                end
                return;
            end
            want  = expected_actions.pop_front();
            wrong = "";
            if (got.action !== want.action) wrong = {wrong, " action"};
            if (got.dest_addr !== want.dest_addr) wrong = {wrong, " dest_addr"};
            if (got.send_identifier !== want.send_identifier) wrong = {wrong, " send_identifier"};
            if (got.channel_out !== want.channel_out) wrong = {wrong, " channel_out"};
            if (got.node_state_out !== want.node_state_out) wrong = {wrong, " node_state_out"};
            if (wrong == "") begin
                act_count[want.action]++;
            end else begin
                n_bad++;
                if (n_bad <= 10) begin
                    $display("%0t mismatch on%s", $time, wrong);
                    show("expected", want);
                    show("got     ", got);
                end
            end
        endfunction
    endclass

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_ready;
    snjuc_pkg::t_in_req            i_in_req    = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    snjuc_pkg::t_out_req           o_out_req;
    logic                          i_cfg_we    = 1'b0;
    logic [snjuc_pkg::CNT_W-1:0]   i_cfg_wdata = '0;

    node_action_scoreboard sb;
    int unsigned           idle_pct     = 24;
    int unsigned           n_sent       = 0;
    int unsigned           quiet_cycles = 0;

    sensor_node_join_uplink_controller u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_req   (o_out_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= idle_pct);
    end

    // Check results and watch for a stalled run.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_response(o_out_req);
        end
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WDOG_LIMIT) begin
                $display("%0t no request moved for %0d cycles", $time, WDOG_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic snjuc_pkg::t_in_req mk(input logic [1:0] cmd,
                                              input logic [snjuc_pkg::ADDR_W-1:0] src,
                                              input logic [snjuc_pkg::IDENT_W-1:0] ident,
                                              input logic [2:0] ptype,
                                              input logic bcast,
                                              input logic [snjuc_pkg::CHAN_W-1:0] chan,
                                              input logic present);
        snjuc_pkg::t_in_req r;
        r.cmd             = cmd;
        r.src_addr        = src;
        r.pkt_identifier  = ident;
        r.pkt_kind        = ptype;
        r.rx_bcast        = bcast;
        r.channel_in      = chan;
        r.channel_present = present;
        return r;
    endfunction

    function automatic snjuc_pkg::t_in_req rand_req(input logic [1:0] cmd);
        return mk(cmd, $urandom, 8'($urandom), 3'($urandom_range(0, 4)),
                  1'($urandom_range(0, 1)), 8'($urandom), 1'($urandom_range(0, 1)));
    endfunction

    function automatic snjuc_pkg::t_in_req rx_pkt(input logic [2:0] ptype);
        snjuc_pkg::t_in_req r;
        r          = rand_req(snjuc_pkg::CMD_RX_PKT);
        r.pkt_kind = ptype;
        r.rx_bcast = 1'b0;
        return r;
    endfunction

    task automatic send_req(input snjuc_pkg::t_in_req r);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(r);
        n_sent++;
    endtask

    // Hold off the sender until every outstanding result has come back.
    task automatic drain();
        if (sb.pending() != 0) begin
            i_in_valid <= 1'b0;
            while (sb.pending() != 0) @(posedge i_clk);
        end
    endtask

    task automatic set_reload(input logic [snjuc_pkg::CNT_W-1:0] v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reload(v);
    endtask

    task automatic run_directed();
        send_req(mk(snjuc_pkg::CMD_INIT, '0, '0, snjuc_pkg::PKT_DATA_REQ, 1'b0, 8'h00, 1'b0));
        send_req(mk(snjuc_pkg::CMD_TICK, '1, '1, PKT_OTHER, 1'b1, 8'hff, 1'b1));
        send_req(mk(snjuc_pkg::CMD_TICK, '0, '0, snjuc_pkg::PKT_DATA_REQ, 1'b0, 8'h00, 1'b0));
        send_req(mk(snjuc_pkg::CMD_TX_DONE, '1, '1, snjuc_pkg::PKT_WAKEUP, 1'b1, 8'hff, 1'b1));
        // broadcast and unknown packet types are dropped
        send_req(mk(snjuc_pkg::CMD_RX_PKT, 32'h1234_5678, 8'h11, snjuc_pkg::PKT_JOIN_RESP,
                    1'b1, 8'h22, 1'b0));
        send_req(mk(snjuc_pkg::CMD_RX_PKT, 32'h8765_4321, 8'h33, PKT_OTHER, 1'b0, 8'h44, 1'b0));
        send_req(mk(snjuc_pkg::CMD_RX_PKT, '1, '1, snjuc_pkg::PKT_JOIN_RESP, 1'b0, 8'hff, 1'b0));
        send_req(mk(snjuc_pkg::CMD_TICK, '0, '0, snjuc_pkg::PKT_DATA_REQ, 1'b0, 8'h00, 1'b0));
        send_req(mk(snjuc_pkg::CMD_TX_DONE, '0, '0, snjuc_pkg::PKT_DATA_REQ, 1'b0, 8'h00, 1'b0));
        send_req(mk(snjuc_pkg::CMD_RX_PKT, '0, '0, snjuc_pkg::PKT_DATA_REQ, 1'b0, 8'h00, 1'b1));
        send_req(mk(snjuc_pkg::CMD_TICK, '1, '1, PKT_OTHER, 1'b0, 8'hff, 1'b1));
        send_req(mk(snjuc_pkg::CMD_RX_PKT, 32'ha5a5_5a5a, 8'h5a, snjuc_pkg::PKT_DATA_REQ,
                    1'b0, 8'h81, 1'b0));
        send_req(mk(snjuc_pkg::CMD_TICK, '0, '0, snjuc_pkg::PKT_DATA_REQ, 1'b0, 8'h00, 1'b0));
        send_req(mk(snjuc_pkg::CMD_TX_DONE, '0, '0, snjuc_pkg::PKT_DATA_REQ, 1'b0, 8'h00, 1'b0));
        send_req(mk(snjuc_pkg::CMD_TICK, '0, '0, snjuc_pkg::PKT_DATA_REQ, 1'b0, 8'h00, 1'b0));
        send_req(mk(snjuc_pkg::CMD_RX_PKT, 32'h0f0f_0f0f, 8'hf0, snjuc_pkg::PKT_DATA_COMP,
                    1'b0, 8'h0f, 1'b1));
        send_req(mk(snjuc_pkg::CMD_RX_PKT, 32'hf0f0_f0f0, 8'h0f, snjuc_pkg::PKT_WAKEUP,
                    1'b0, 8'hf0, 1'b0));
        send_req(mk(snjuc_pkg::CMD_TICK, '0, '0, snjuc_pkg::PKT_DATA_REQ, 1'b0, 8'h00, 1'b0));
        send_req(mk(snjuc_pkg::CMD_TX_DONE, '0, '0, snjuc_pkg::PKT_DATA_REQ, 1'b0, 8'h00, 1'b0));
        // a saved channel of zero still counts as present
        send_req(mk(snjuc_pkg::CMD_INIT, '1, '1, PKT_OTHER, 1'b1, 8'h00, 1'b1));
        send_req(mk(snjuc_pkg::CMD_INIT, '0, '0, snjuc_pkg::PKT_DATA_REQ, 1'b0, 8'hff, 1'b1));
        send_req(mk(snjuc_pkg::CMD_RX_PKT, '0, '0, snjuc_pkg::PKT_JOIN_RESP, 1'b0, 8'h00, 1'b1));
        send_req(mk(snjuc_pkg::CMD_TICK, '1, '1, PKT_OTHER, 1'b1, 8'hff, 1'b0));
    endtask

    task automatic run_random(input int unsigned n);
        int unsigned        stop_at;
        int unsigned        k;
        snjuc_pkg::t_in_req r;
        stop_at = n_sent + n;
        while (n_sent < stop_at) begin
            k = $urandom_range(0, 99);
            if (k < 22) begin
                send_req(rand_req(2'($urandom_range(0, 3))));
            end else if (k < 40) begin
                if ($urandom_range(0, 3) == 0) begin
                    r = rand_req(snjuc_pkg::CMD_INIT);
                    r.channel_present = 1'b0;
                    send_req(r);
                end
                send_req(rand_req(snjuc_pkg::CMD_TICK));
                send_req(rand_req(snjuc_pkg::CMD_TX_DONE));
                r = rx_pkt(snjuc_pkg::PKT_JOIN_RESP);
                if ($urandom_range(0, 7) == 0) r.channel_in = '0;
                send_req(r);
                send_req(rand_req(snjuc_pkg::CMD_TICK));
                send_req(rand_req(snjuc_pkg::CMD_TX_DONE));
            end else if (k < 60) begin
                send_req(rx_pkt(snjuc_pkg::PKT_DATA_REQ));
                send_req(rand_req(snjuc_pkg::CMD_TICK));
                send_req(rand_req(snjuc_pkg::CMD_TX_DONE));
            end else if (k < 80) begin
                send_req(rx_pkt($urandom_range(0, 1) ? snjuc_pkg::PKT_DATA_COMP :
                                                       snjuc_pkg::PKT_WAKEUP));
                repeat ($urandom_range(1, 16)) send_req(rand_req(snjuc_pkg::CMD_TICK));
            end else if (k < 97) begin
                send_req(rand_req($urandom_range(0, 2) ? snjuc_pkg::CMD_TICK :
                                                         snjuc_pkg::CMD_TX_DONE));
            end else begin
                drain();
            end
        end
    endtask

    // Run the idle countdown to a radio reinit; a zero reload only walks its first wrapped ticks.
    task automatic run_countdown(input logic [snjuc_pkg::CHAN_W-1:0] chan);
        int unsigned ticks;
        send_req(mk(snjuc_pkg::CMD_INIT, $urandom, 8'($urandom), snjuc_pkg::PKT_WAKEUP, 1'b0,
                    chan, 1'b1));
        send_req(rand_req(snjuc_pkg::CMD_TICK));
        ticks = (sb.reload == '0) ? 20 : 32'(sb.reload);
        repeat (ticks) send_req(rand_req(snjuc_pkg::CMD_TICK));
        send_req(rand_req(snjuc_pkg::CMD_TX_DONE));
    endtask

    initial begin
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        set_reload(16'd1);
        run_random(140);
        // steady stretch: neither side idles
        set_reload(16'd3);
        idle_pct = 0;
        run_random(140);
        idle_pct = 24;
        set_reload(16'd6);
        run_countdown(8'h3c);
        set_reload(16'd0);
        run_countdown(8'h00);
        set_reload(16'd2);
        run_random(140);
        set_reload(16'($urandom_range(4, 12)));
        run_random(140);

        drain();
        repeat (SETTLE_LIMIT) @(posedge i_clk);
        $display("covered %0d requests and %0d results over reloads 300, 1, 3, 6, 0, 2, %0d",
                 sb.n_req, sb.n_res, sb.reload);
        $display("join req %0d, join comp %0d, uplink %0d, reinit %0d, channel %0d, wake %0d",
                 sb.act_count[snjuc_pkg::ACT_JOIN_REQ], sb.act_count[snjuc_pkg::ACT_JOIN_COMP],
                 sb.act_count[snjuc_pkg::ACT_UPLINK], sb.act_count[snjuc_pkg::ACT_REINIT],
                 sb.act_count[snjuc_pkg::ACT_SET_CHANNEL], sb.act_count[snjuc_pkg::ACT_WAKE]);
        if (sb.n_bad == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/snjuc_pkg.sv
rtl/snjuc_core.sv
rtl/sensor_node_join_uplink_controller.sv
dv/tb_sensor_node_join_uplink_controller.sv
